// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/kwsa_pkg.sv =====
// Package with types and constants of the keyed Welford statistics accumulator.
package kwsa_pkg;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ACC_W = 63;
    localparam int unsigned NODE_W = 14;
    localparam int unsigned HOUR_W = 5;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [62:0] ACC_MAX = {63{1'b1}};
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [1:0] CH_TOTAL = 2'd0;
    localparam logic [1:0] CH_CONG = 2'd1;
    localparam logic [1:0] CH_ENERGY = 2'd2;

    // Per-node record of one table row.
    typedef struct packed {
        logic [31:0] count;
        logic [62:0] abs_sum;
        logic [31:0] positive;
        logic [31:0] max_v;
        logic [31:0] min_v;
    } node_rec_t;

    typedef struct packed {
        logic [31:0] mean;
        logic [62:0] sq_dev;
    } chan_rec_t;

    typedef struct packed {
        logic [63:0] sum;
        logic [31:0] count;
    } hour_rec_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
    endfunction

    function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add63 = s[63] ? ACC_MAX : s[62:0];
    endfunction
endpackage

// ===== src/keyed_welford_stats_accumulator_top.sv =====
// Top level of the keyed Welford statistics accumulator.
// Each accepted request names a node slot, an hour and three signed Q16.16
// spreads. The block reads the node record, runs a Welford update for each
// spread, updates the node sums, count, extremes and the hourly bucket, and
// presents the updated record on the m_ channel as one result.
// Requests with a node index at or beyond NODE_SLOTS produce no result.
// The sequencer takes no new request until the result of the last one has
// been moved into the result register. For each spread it runs a channel
// table read, a mean division on one shared radix-2 divider, one 33x33
// product of the two deviations and the table write. The node and hourly
// tables are read before the first spread and written after the last.
// s_ready is high only while the sequencer is idle; a finished result waits
// in the sequencer until the result register is free.
// After reset a clearing pass writes every node row, the three used channel
// lanes of each node row and every hourly bucket, with the spare hourly row
// past the last bucket; s_ready is low during the pass.
// When the receiver stalls, the result stays in its register and the block
// finishes at most one more item before it waits.
module keyed_welford_stats_accumulator_top #(
    parameter int unsigned NODE_SLOTS = 16384,
    parameter int unsigned HOUR_BUCKETS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [13:0]        s_node_index,
    input  logic [4:0]         s_hour_of_day,
    input  logic signed [31:0] s_spread_value,
    input  logic signed [31:0] s_congestion_spread,
    input  logic signed [31:0] s_energy_spread_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_sample_count,
    output logic signed [31:0] m_mean_total,
    output logic [62:0]        m_sq_dev_total,
    output logic signed [31:0] m_mean_congestion,
    output logic [62:0]        m_sq_dev_congestion,
    output logic signed [31:0] m_mean_energy,
    output logic [62:0]        m_sq_dev_energy,
    output logic [62:0]        m_abs_sum_total,
    output logic [31:0]        m_positive_samples,
    output logic [63:0]        m_extremes_packed,
    output logic signed [63:0] m_hour_bucket_sum,
    output logic [31:0]        m_hour_bucket_count
);
    localparam int unsigned NA_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int unsigned CA_W = $clog2(NODE_SLOTS * 4);
    localparam int unsigned HA_W = $clog2(NODE_SLOTS * HOUR_BUCKETS + 1);
    localparam int unsigned HB_W = $clog2(HOUR_BUCKETS + 1);
    localparam int unsigned NODE_RW = $bits(kwsa_pkg::node_rec_t);
    localparam int unsigned CHAN_RW = $bits(kwsa_pkg::chan_rec_t);
    localparam int unsigned HOUR_RW = $bits(kwsa_pkg::hour_rec_t);
    localparam logic [HA_W-1:0] HOUR_LAST = HA_W'(NODE_SLOTS * HOUR_BUCKETS - 1);
    localparam logic [HA_W-1:0] NODE_LAST = HA_W'(NODE_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_CREAD, ST_CWAIT, ST_DIV,
        ST_MUL, ST_CWRITE, ST_NODE, ST_OUT
    } state_t;

    state_t state_reg;
    logic [HA_W-1:0] clr_reg;
    logic [NA_W-1:0] node_reg;
    logic [4:0] hour_reg;
    logic hour_ok_reg;
    logic signed [31:0] x_reg [3];
    logic [1:0] ch_reg;
    logic div_start_reg;
    kwsa_pkg::node_rec_t nrec_reg;
    kwsa_pkg::hour_rec_t hrec_reg;
    kwsa_pkg::chan_rec_t crec_reg [3];
    logic signed [32:0] d1_reg, d2_reg;
    logic [31:0] mnew_reg;
    logic [63:0] prod_reg;

    // Table ports.
    logic n_we, c_we, h_we;
    logic [NA_W-1:0] n_addr;
    logic [CA_W-1:0] c_addr;
    logic [HA_W-1:0] h_addr;
    kwsa_pkg::node_rec_t n_wdata, n_rdata;
    kwsa_pkg::chan_rec_t c_wdata, c_rdata;
    kwsa_pkg::hour_rec_t h_wdata, h_rdata;

    logic div_done;
    logic signed [33:0] div_q;
    logic signed [33:0] mnew_full;
    logic [32:0] ad1, ad2;
    logic [62:0] sq_sum;
    logic signed [31:0] x_cur;
    logic [63:0] hs_next;
    logic signed [64:0] hs_wide;
    logic [HA_W-1:0] hour_base;

    kwsa_ram #(.WIDTH(NODE_RW), .DEPTH(NODE_SLOTS)) u_node_ram (
        .aclk(aclk), .we(n_we), .addr(n_addr), .wdata(n_wdata), .rdata(n_rdata));
    kwsa_ram #(.WIDTH(CHAN_RW), .DEPTH(NODE_SLOTS * 4)) u_chan_ram (
        .aclk(aclk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata));
    kwsa_ram #(.WIDTH(HOUR_RW), .DEPTH(NODE_SLOTS * HOUR_BUCKETS + 1)) u_hour_ram (
        .aclk(aclk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

    kwsa_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start_reg),
        .dividend({d1_reg[32], d1_reg}), .divisor(nrec_reg.count),
        .done(div_done), .quotient(div_q));

    assign x_cur = x_reg[ch_reg];
    assign hour_base = HA_W'(node_reg) * HA_W'(HOUR_BUCKETS);
    assign mnew_full = $signed({{2{crec_reg[ch_reg].mean[31]}}, crec_reg[ch_reg].mean}) + div_q;
    assign ad1 = d1_reg[32] ? (33'd0 - d1_reg) : d1_reg;
    assign ad2 = d2_reg[32] ? (33'd0 - d2_reg) : d2_reg;
    assign sq_sum = kwsa_pkg::sat_add63(crec_reg[ch_reg].sq_dev, {15'd0, prod_reg[63:16]});
    assign hs_wide = $signed({hrec_reg.sum[63], hrec_reg.sum}) +
        $signed({{33{x_reg[0][31]}}, x_reg[0]});

    always_comb begin
        if (hs_wide[64] != hs_wide[63]) begin
            hs_next = hs_wide[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
            hs_next = hs_wide[63:0];
        end
    end

    always_comb begin
        n_we = 1'b0;
        c_we = 1'b0;
        h_we = 1'b0;
        n_addr = node_reg;
        c_addr = {node_reg, ch_reg};
        h_addr = hour_ok_reg ? (hour_base + HA_W'(hour_reg)) : HOUR_LAST + HA_W'(1);
        n_wdata = nrec_reg;
        c_wdata = '0;
        h_wdata = hrec_reg;
        case (state_reg)
            ST_CLEAR: begin
                n_we = (clr_reg <= NODE_LAST);
                c_we = (clr_reg <= NODE_LAST);
                h_we = 1'b1;
                n_addr = NA_W'(clr_reg);
                h_addr = clr_reg;
                n_wdata = '{count: '0, abs_sum: '0, positive: '0,
                    max_v: kwsa_pkg::Q_MIN, min_v: kwsa_pkg::Q_MAX};
                h_wdata = '0;
                c_addr = CA_W'({NA_W'(clr_reg), ch_reg});
            end
            ST_IDLE: begin
                n_addr = NA_W'(s_node_index);
            end
            ST_CWRITE: begin
                c_we = 1'b1;
                c_wdata = '{mean: mnew_reg, sq_dev: sq_sum};
            end
            ST_NODE: begin
                n_we = 1'b1;
                h_we = hour_ok_reg;
            end
            default: begin
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            ch_reg <= kwsa_pkg::CH_TOTAL;
            m_valid <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == ST_CWAIT);
            if (m_valid && m_ready && state_reg != ST_OUT) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    // Of the four channel lanes a row, only the three used ones are cleared.
                    if (ch_reg != kwsa_pkg::CH_ENERGY && clr_reg <= NODE_LAST) begin
                        ch_reg <= ch_reg + 2'd1;
                    end else begin
                        ch_reg <= kwsa_pkg::CH_TOTAL;
                        clr_reg <= clr_reg + HA_W'(1);
                        if (clr_reg == HOUR_LAST + HA_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_IDLE: begin
                    if (s_valid && s_ready && (32'(s_node_index) < 32'(NODE_SLOTS))) begin
                        node_reg <= NA_W'(s_node_index);
                        hour_reg <= s_hour_of_day;
                        hour_ok_reg <= (HB_W'(s_hour_of_day) < HB_W'(HOUR_BUCKETS));
                        x_reg[0] <= s_spread_value;
                        x_reg[1] <= s_congestion_spread;
                        x_reg[2] <= s_energy_spread_value;
                        ch_reg <= kwsa_pkg::CH_TOTAL;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    nrec_reg.count <= kwsa_pkg::sat_inc(n_rdata.count);
                    nrec_reg.abs_sum <= n_rdata.abs_sum;
                    nrec_reg.positive <= n_rdata.positive;
                    nrec_reg.max_v <= n_rdata.max_v;
                    nrec_reg.min_v <= n_rdata.min_v;
                    hrec_reg <= hour_ok_reg ? h_rdata : '0;
                    state_reg <= ST_CREAD;
                end
                ST_CREAD: begin
                    state_reg <= ST_CWAIT;
                end
                ST_CWAIT: begin
                    crec_reg[ch_reg] <= c_rdata;
                    d1_reg <= $signed({x_cur[31], x_cur}) -
                        $signed({c_rdata.mean[31], c_rdata.mean});
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        mnew_reg <= mnew_full[31:0];
                        d2_reg <= $signed({x_cur[31], x_cur}) - mnew_full[32:0];
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // Magnitudes are below 2^32; a 33x33 product fits in 64 bits.
                    prod_reg <= {31'd0, ad1} * {31'd0, ad2};
                    state_reg <= ST_CWRITE;
                end
                ST_CWRITE: begin
                    crec_reg[ch_reg] <= '{mean: mnew_reg, sq_dev: sq_sum};
                    if (ch_reg == kwsa_pkg::CH_ENERGY) begin
                        state_reg <= ST_NODE;
                    end else begin
                        ch_reg <= ch_reg + 2'd1;
                        state_reg <= ST_CREAD;
                    end
                end
                ST_NODE: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // The record waits here until the result register is free.
                    if (!m_valid || m_ready) begin
                        m_valid <= 1'b1;
                        m_sample_count <= nrec_reg.count;
                        m_mean_total <= crec_reg[0].mean;
                        m_sq_dev_total <= crec_reg[0].sq_dev;
                        m_mean_congestion <= crec_reg[1].mean;
                        m_sq_dev_congestion <= crec_reg[1].sq_dev;
                        m_mean_energy <= crec_reg[2].mean;
                        m_sq_dev_energy <= crec_reg[2].sq_dev;
                        m_abs_sum_total <= nrec_reg.abs_sum;
                        m_positive_samples <= nrec_reg.positive;
                        m_extremes_packed <= {nrec_reg.max_v, nrec_reg.min_v};
                        m_hour_bucket_sum <= hrec_reg.sum;
                        m_hour_bucket_count <= hrec_reg.count;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (state_reg == ST_CWAIT) begin
            // Node and hourly fields are updated while the first channel runs.
            if (ch_reg == kwsa_pkg::CH_TOTAL) begin
                nrec_reg.abs_sum <= kwsa_pkg::sat_add63(nrec_reg.abs_sum,
                    x_reg[0][31] ? {31'd0, 32'd0 - x_reg[0]} : {31'd0, x_reg[0]});
                if (!x_reg[0][31] && x_reg[0] != 32'sd0) begin
                    nrec_reg.positive <= kwsa_pkg::sat_inc(nrec_reg.positive);
                end
                if (x_reg[0] > $signed(nrec_reg.max_v)) begin
                    nrec_reg.max_v <= x_reg[0];
                end
                if (x_reg[0] < $signed(nrec_reg.min_v)) begin
                    nrec_reg.min_v <= x_reg[0];
                end
                if (hour_ok_reg) begin
                    hrec_reg.sum <= hs_next;
                    hrec_reg.count <= kwsa_pkg::sat_inc(hrec_reg.count);
                end
            end
        end
    end
endmodule

// ===== src/kwsa_ram.sv =====
// Generic single-port RAM with registered read.
module kwsa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/kwsa_div.sv =====
// Radix-2 restoring divider: signed 34-bit dividend by unsigned 32-bit count.
module kwsa_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [33:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [33:0] quotient
);
    logic [33:0] mag_reg, mag_next;
    logic [33:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    always_comb begin
        mag_next = mag_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg, mag_reg[33]} - {2'b00, den_reg};
        if (busy_reg) begin
            mag_next = {mag_reg[32:0], 1'b0};
            if (!trial[33]) begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[32:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], mag_reg[33]};
                quo_next = {quo_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end else begin
            done <= busy_reg && (cnt_reg == 6'd1);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd34;
            end else begin
                busy_reg <= busy_next;
                cnt_reg <= cnt_next;
            end
        end
        if (start) begin
            mag_reg <= dividend[33] ? (34'd0 - dividend) : dividend;
            neg_reg <= dividend[33];
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = neg_reg ? (34'sd0 - $signed(quo_reg)) : $signed(quo_reg);
endmodule

// ===== src/kwsa_checker.sv =====
// Port-level checker for the accumulator, bound to the top level.
`include "assert_macros.svh"
module kwsa_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic [31:0] m_sample_count,
    input logic [31:0] m_positive_samples,
    input logic [31:0] m_hour_bucket_count
);
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_IMPL(a_count_nonzero, aclk, aresetn, m_valid, m_sample_count != 32'd0)
    `ASSERT_IMPL(a_pos_le_count, aclk, aresetn, m_valid, m_positive_samples <= m_sample_count)
    `ASSERT_IMPL(a_hour_le_count, aclk, aresetn, m_valid, m_hour_bucket_count <= m_sample_count)
    `ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

bind keyed_welford_stats_accumulator_top kwsa_checker u_kwsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_sample_count(m_sample_count),
    .m_positive_samples(m_positive_samples), .m_hour_bucket_count(m_hour_bucket_count));
